[hw/rtl/u2u8s_pkg.sv]
package u2u8s_pkg;

  localparam logic [15:0] CapacityReset = 16'd256;
  localparam logic [20:0] ReplacementCp = 21'h00FFFD;
  localparam logic [20:0] SupplBase     = 21'h010000;
  localparam logic [20:0] CtrlLimit     = 21'h000020;
  localparam logic [20:0] DelCp         = 21'h00007F;
  localparam logic [20:0] DotCp         = 21'h00002E;
  localparam logic [20:0] OneByteLimit  = 21'h000080;
  localparam logic [20:0] TwoByteLimit  = 21'h000800;
  localparam logic [20:0] ThreeByteLim  = 21'h010000;
  localparam logic [5:0]  HighTag       = 6'b110110;
  localparam logic [5:0]  LowTag        = 6'b110111;
  localparam int unsigned EntryBytes    = 6;

  typedef enum logic [1:0] {
    KindZero,
    KindHigh,
    KindLow,
    KindPlain
  } unit_kind_e;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        run_end;
    logic        string_done;
    logic        was_cut;
    logic [15:0] byte_count;
  } out_res_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } enc_t;

  // One work entry between front and back: bytes of up to two characters
  // plus the optional closing status.
  typedef struct packed {
    logic [EntryBytes-1:0][7:0] bytes;
    logic [2:0]                 nbytes;
    logic                       status;
    logic                       cut;
    logic [15:0]                base;
  } entry_t;

  function automatic enc_t encode_cp(input logic [20:0] cp_in);
    logic [20:0] cp;
    enc_t        e;
    cp = cp_in;
    e  = '0;
    if (cp < CtrlLimit || cp == DelCp) begin
      cp = DotCp;
    end
    if (cp < OneByteLimit) begin
      e.n    = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < TwoByteLimit) begin
      e.n    = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < ThreeByteLim) begin
      e.n    = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

[hw/rtl/utf16_to_utf8_sanitizing_core.sv]
// UTF-16 to UTF-8 transcoder with sanitizing.
// Input queue side: present a code unit on in_req_i and raise push; the unit
// is taken at an edge where push is high and full is low. A unit marked
// last_unit closes the string and always yields one status result.
// Result queue side: while empty is low the oldest result sits on out_res_o;
// raise pop to take it. Each result carries one UTF-8 byte or the closing
// status (byte count and cut flag).
// Configuration: the capacity register is written through cfg_valid_i /
// cfg_data_i; cfg_ready_o is always high. Write it only while idle.
// Timing: the front classifies and encodes a unit in the cycle it is taken,
// so one unit can be accepted every cycle while the work queue has room. The
// first result of a unit passes through the work queue and the output register
// before it shows up on out_res_o. The back drains one result per cycle while
// pop keeps up; the single-byte result port sets the sustained rate.
// Reset: capacity returns to 256, all string state clears, the work queue and
// the output register empty.
// Stall: when pop stays low the output register holds, the work queue fills
// and full rises; nothing is lost or repeated.
module utf16_to_utf8_sanitizing_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  u2u8s_pkg::in_req_t  in_req_i,
  output logic                empty,
  input  logic                pop,
  output u2u8s_pkg::out_res_t out_res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import u2u8s_pkg::*;

  logic [15:0] cap_q;
  logic        accept;
  logic        ent_valid;
  entry_t      ent;
  logic        q_valid, q_pop;
  entry_t      q_head;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Capacity register: hold until a configuration request lands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // Front: track surrogates, capacity and halting; encode up to two
  // characters per unit into one work entry.
  u2u8s_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_req_i      (in_req_i),
    .capacity_i    (cap_q),
    .entry_valid_o (ent_valid),
    .entry_o       (ent)
  );

  // Work queue: decouple the encoder from the byte drain.
  u2u8s_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (ent_valid),
    .wr_data_i (ent),
    .full_o    (full),
    .rd_i      (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (q_head)
  );

  // Back: advance through the head entry one result per cycle while pop keeps up.
  u2u8s_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .head_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_res_o    (out_res_o)
  );

  // A status result is always the last one of its unit and carries no byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_res_o.string_done) |-> (out_res_o.run_end && !out_res_o.has_byte))
    else $error("status result not closing its run");

  // Within a run, the count grows by one per byte and holds on the status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !out_res_o.run_end) |=>
      (!empty && ((out_res_o.has_byte &&
                   out_res_o.byte_count == $past(out_res_o.byte_count) + 16'd1) ||
                  (!out_res_o.has_byte &&
                   out_res_o.byte_count == $past(out_res_o.byte_count)))))
    else $error("byte count out of sequence");

  // Pending work reaches the output register in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && empty) |=> !empty)
    else $error("back failed to load pending work");

endmodule

[hw/rtl/u2u8s_front.sv]
module u2u8s_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  u2u8s_pkg::in_req_t in_req_i,
  input  logic [15:0]       capacity_i,
  output logic              entry_valid_o,
  output u2u8s_pkg::entry_t entry_o
);
  import u2u8s_pkg::*;

  logic        hp_q, hp_d;
  logic [9:0]  hb_q, hb_d;
  logic [15:0] em_q, em_d;
  logic        halted_q, halted_d;
  logic        cut_q, cut_d;

  unit_kind_e  kind;
  logic [15:0] u;
  logic        last;
  logic        cap_zero, run, hp_in;
  logic        use0, fit0, use1, fit1, fresh, hold_new, halt0;
  logic [20:0] cp0, cp1;
  enc_t        e0, e1;
  logic [16:0] sum0, sum1;
  logic [15:0] em_a;
  logic [2:0]  off, n1e, j;

  assign u        = in_req_i.code_unit;
  assign last     = in_req_i.last_unit;
  assign cap_zero = (capacity_i == 16'd0);

  always_comb begin
    if (u == 16'd0) begin
      kind = KindZero;
    end else if (u[15:10] == HighTag) begin
      kind = KindHigh;
    end else if (u[15:10] == LowTag) begin
      kind = KindLow;
    end else begin
      kind = KindPlain;
    end
  end

  always_comb begin
    run   = !(halted_q || cap_zero);
    hp_in = hp_q && !cap_zero;

    // Held high surrogate: pair it, or replace it.
    use0 = run && hp_in;
    cp0  = (kind == KindLow) ? SupplBase + {1'b0, hb_q, u[9:0]} : ReplacementCp;
    e0   = encode_cp(cp0);
    sum0 = {1'b0, em_q} + {14'd0, e0.n};
    fit0 = sum0 < {1'b0, capacity_i};
    halt0 = use0 && !fit0;
    em_a = (use0 && fit0) ? sum0[15:0] : em_q;

    // New unit on its own.
    fresh    = run && !(use0 && ((kind == KindLow) || !fit0));
    hold_new = 1'b0;
    use1     = 1'b0;
    cp1      = {5'd0, u};
    unique case (kind)
      KindZero:  cp1 = {5'd0, u};
      KindHigh: begin
        hold_new = fresh && !last;
        use1     = fresh && last;
        cp1      = ReplacementCp;
      end
      KindLow: begin
        use1 = fresh;
        cp1  = ReplacementCp;
      end
      KindPlain: use1 = fresh;
      default:   cp1 = {5'd0, u};
    endcase
    e1   = encode_cp(cp1);
    sum1 = {1'b0, em_a} + {14'd0, e1.n};
    fit1 = sum1 < {1'b0, capacity_i};

    hp_d     = run ? hold_new : hp_in;
    hb_d     = hold_new ? u[9:0] : hb_q;
    em_d     = (use1 && fit1) ? sum1[15:0] : em_a;
    halted_d = !run || halt0 || (fresh && kind == KindZero) || (use1 && !fit1);
    cut_d    = cut_q || halt0 || (use1 && !fit1);

    // Pack bytes of both characters back to back.
    off = (use0 && fit0) ? e0.n : 3'd0;
    n1e = (use1 && fit1) ? e1.n : 3'd0;
    entry_o        = '0;
    entry_o.nbytes = off + n1e;
    entry_o.status = last;
    entry_o.cut    = cut_d;
    entry_o.base   = em_q;
    for (int i = 0; i < EntryBytes; i++) begin
      j = 3'(i) - off;
      if (3'(i) < off) begin
        entry_o.bytes[i] = e0.b[i[1:0]];
      end else if (j < 3'd4) begin
        entry_o.bytes[i] = e1.b[j[1:0]];
      end
    end
    entry_valid_o = accept_i && (last || (entry_o.nbytes != 3'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q     <= 1'b0;
      hb_q     <= '0;
      em_q     <= '0;
      halted_q <= 1'b0;
      cut_q    <= 1'b0;
    end else if (accept_i) begin
      if (last) begin
        hp_q     <= 1'b0;
        hb_q     <= '0;
        em_q     <= '0;
        halted_q <= 1'b0;
        cut_q    <= 1'b0;
      end else begin
        hp_q     <= hp_d;
        hb_q     <= hb_d;
        em_q     <= em_d;
        halted_q <= halted_d;
        cut_q    <= cut_d;
      end
    end
  end

endmodule

[hw/rtl/u2u8s_queue.sv]
module u2u8s_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  u2u8s_pkg::entry_t wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              valid_o,
  output u2u8s_pkg::entry_t rd_data_o
);
  import u2u8s_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign valid_o   = (cnt_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/u2u8s_back.sv]
module u2u8s_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  u2u8s_pkg::entry_t   head_i,
  output logic                head_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output u2u8s_pkg::out_res_t out_res_o
);
  import u2u8s_pkg::*;

  logic [2:0] idx_q;
  logic       out_valid_q;
  out_res_t   out_q;
  out_res_t   res;
  logic       load, is_byte, last_res;

  assign empty_o   = !out_valid_q;
  assign out_res_o = out_q;
  assign load      = head_valid_i && (!out_valid_q || pop_i);
  assign head_pop_o = load && last_res;

  always_comb begin
    is_byte  = idx_q < head_i.nbytes;
    last_res = is_byte ? ((idx_q == head_i.nbytes - 3'd1) && !head_i.status) : 1'b1;
    res             = '0;
    res.has_byte    = is_byte;
    res.out_byte    = is_byte ? head_i.bytes[idx_q] : 8'd0;
    res.run_end     = last_res;
    res.string_done = !is_byte;
    res.was_cut     = !is_byte && head_i.cut;
    res.byte_count  = head_i.base + {13'd0, idx_q} + {15'd0, is_byte};
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= last_res ? 3'd0 : idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[tb/tb_utf16_to_utf8_sanitizing_core.sv]
module tb_utf16_to_utf8_sanitizing_core;
  import u2u8s_pkg::*;

  // Clock period is 10; allow several times the slowest plausible run.
  localparam int TimeoutTime  = 6_000_000;
  // Cycles to let a quiet request settle inside the block before a config write.
  localparam int SettleCycles = 8;
  // Cycles to watch for stray results once everything expected has arrived.
  localparam int TailCycles   = 100;
  localparam int DrainLimit   = 20_000;
  localparam int HoldCycles   = 200;
  localparam int NumPhases    = 10;
  localparam int PhaseUnits   = 36;

  // Code points and UTF-8 marks used by the predictor.
  localparam logic [20:0] ReplChar   = 21'h00FFFD;
  localparam logic [20:0] SupplStart = 21'h010000;
  localparam logic [20:0] DotChar    = 21'h00002E;
  localparam logic [20:0] DelChar    = 21'h00007F;
  localparam logic [20:0] FirstPrint = 21'h000020;
  localparam logic [7:0]  LeadTwo    = 8'hC0;
  localparam logic [7:0]  LeadThree  = 8'hE0;
  localparam logic [7:0]  LeadFour   = 8'hF0;
  localparam logic [7:0]  ContMark   = 8'h80;

  // How a directed row is checked: by the predictor, or against typed values.
  typedef enum logic [1:0] {
    RowPredicted,
    RowTypedNone,
    RowTypedOne
  } row_check_e;

  typedef struct packed {
    logic        set_cap;
    logic [15:0] cap;
    logic [15:0] unit;
    logic        last;
    row_check_e  check;
    out_res_t    typed;
  } dir_row_t;

  localparam int NumRows = 26;

  // Directed requests: extremes, every unit class, and the corner cases of the
  // surrogate, terminator and capacity handling. The first rows run at the
  // reset capacity of 256.
  localparam dir_row_t DirRows [NumRows] = '{
    // plain ASCII, then a terminator and a unit that must be ignored
    '{1'b0, 16'd0, 16'h0041, 1'b0, RowTypedOne, '{8'h41, 1'b1, 1'b1, 1'b0, 1'b0, 16'd1}},
    '{1'b0, 16'd0, 16'h0000, 1'b0, RowTypedNone, '0},
    '{1'b0, 16'd0, 16'h0042, 1'b1, RowTypedOne, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 16'd1}},
    // C0 control and DEL both become a dot
    '{1'b0, 16'd0, 16'h0001, 1'b0, RowTypedOne, '{8'h2E, 1'b1, 1'b1, 1'b0, 1'b0, 16'd1}},
    '{1'b0, 16'd0, 16'h007F, 1'b0, RowTypedOne, '{8'h2E, 1'b1, 1'b1, 1'b0, 1'b0, 16'd2}},
    // two- and three-byte forms, top of the BMP
    '{1'b0, 16'd0, 16'h00E9, 1'b0, RowPredicted, '0},
    '{1'b0, 16'd0, 16'h0800, 1'b0, RowPredicted, '0},
    '{1'b0, 16'd0, 16'hFFFF, 1'b0, RowPredicted, '0},
    // valid pairs, including the highest code point
    '{1'b0, 16'd0, 16'hD83D, 1'b0, RowTypedNone, '0},
    '{1'b0, 16'd0, 16'hDE00, 1'b0, RowPredicted, '0},
    '{1'b0, 16'd0, 16'hDBFF, 1'b0, RowTypedNone, '0},
    '{1'b0, 16'd0, 16'hDFFF, 1'b0, RowPredicted, '0},
    // held high followed by a plain unit, then a lone low
    '{1'b0, 16'd0, 16'hD800, 1'b0, RowTypedNone, '0},
    '{1'b0, 16'd0, 16'h0041, 1'b0, RowPredicted, '0},
    '{1'b0, 16'd0, 16'hDC00, 1'b0, RowPredicted, '0},
    // high surrogate as the closing unit
    '{1'b0, 16'd0, 16'hD800, 1'b1, RowPredicted, '0},
    // held high, then a three-byte closing unit: the longest burst
    '{1'b0, 16'd0, 16'hD801, 1'b0, RowTypedNone, '0},
    '{1'b0, 16'd0, 16'h4E2D, 1'b1, RowPredicted, '0},
    // held high, then a terminator that also closes
    '{1'b0, 16'd0, 16'hD800, 1'b0, RowTypedNone, '0},
    '{1'b0, 16'd0, 16'h0000, 1'b1, RowPredicted, '0},
    // zero capacity: empty result, no cut
    '{1'b1, 16'd0, 16'h0041, 1'b1, RowTypedOne, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 16'd0}},
    // capacity one: only the terminator slot, first character is cut
    '{1'b1, 16'd1, 16'h0041, 1'b1, RowTypedOne, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'd0}},
    // a pair that does not fit drops the held surrogate and cuts
    '{1'b1, 16'd4, 16'h0041, 1'b0, RowTypedOne, '{8'h41, 1'b1, 1'b1, 1'b0, 1'b0, 16'd1}},
    '{1'b0, 16'd0, 16'hD800, 1'b0, RowTypedNone, '0},
    '{1'b0, 16'd0, 16'hDC00, 1'b1, RowTypedOne, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'd1}},
    // largest capacity
    '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, RowPredicted, '0}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  logic     full;
  in_req_t  in_req;
  logic     empty;
  logic     pop;
  out_res_t out_res;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [15:0] cfg_data;

  utf16_to_utf8_sanitizing_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_req_i    (in_req),
    .empty       (empty),
    .pop         (pop),
    .out_res_o   (out_res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // Predictor state: a private copy of the capacity and the per-string state.
  logic [15:0] cap_shadow;
  logic        high_held;
  logic [9:0]  high_payload;
  logic [15:0] bytes_out;
  logic        string_halted;
  logic        string_cut;

  // Results of the request being predicted, and all results still owed.
  out_res_t unit_results[$];
  out_res_t pending_utf8[$];

  int errors;
  int units_sent;
  int units_ignored;
  int results_checked;
  int cap_writes;
  bit no_idle;
  bit hold_req;

  // Generate the clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // End the run if the block hangs.
  initial begin
    #(TimeoutTime);
    $display("utf16_to_utf8_sanitizing_core verification failed");
    $finish;
  end

  function automatic unit_kind_e classify_unit(input logic [15:0] u);
    if (u == 16'h0000) return KindZero;
    if (u >= 16'hD800 && u <= 16'hDBFF) return KindHigh;
    if (u >= 16'hDC00 && u <= 16'hDFFF) return KindLow;
    return KindPlain;
  endfunction

  // Encode one code point; append its bytes if they fit with the terminator
  // slot, else halt the string with the cut flag and drop any held surrogate.
  task automatic emit_code_point(input logic [20:0] cp_in);
    logic [20:0] cp;
    logic [7:0]  b [4];
    int          n;
    cp = cp_in;
    if (cp < FirstPrint || cp == DelChar) cp = DotChar;
    if (cp < 21'h80) begin
      n    = 1;
      b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      n    = 2;
      b[0] = LeadTwo | 8'(cp[10:6]);
      b[1] = ContMark | 8'(cp[5:0]);
    end else if (cp < SupplStart) begin
      n    = 3;
      b[0] = LeadThree | 8'(cp[15:12]);
      b[1] = ContMark | 8'(cp[11:6]);
      b[2] = ContMark | 8'(cp[5:0]);
    end else begin
      n    = 4;
      b[0] = LeadFour | 8'(cp[20:18]);
      b[1] = ContMark | 8'(cp[17:12]);
      b[2] = ContMark | 8'(cp[11:6]);
      b[3] = ContMark | 8'(cp[5:0]);
    end
    if (int'(bytes_out) + n >= int'(cap_shadow)) begin
      string_cut    = 1'b1;
      string_halted = 1'b1;
      high_held     = 1'b0;
    end else begin
      for (int i = 0; i < n; i++) begin
        bytes_out++;
        unit_results.push_back('{b[i], 1'b1, 1'b0, 1'b0, 1'b0, bytes_out});
      end
    end
  endtask

  // Handle a unit with no high surrogate held.
  task automatic transcode_fresh(input logic [15:0] u, input logic last);
    case (classify_unit(u))
      KindZero: begin
        string_halted = 1'b1;
      end
      KindHigh: begin
        if (last) begin
          emit_code_point(ReplChar);
        end else begin
          high_held    = 1'b1;
          high_payload = u[9:0];
        end
      end
      KindLow: begin
        emit_code_point(ReplChar);
      end
      default: begin
        emit_code_point({5'b0, u});
      end
    endcase
  endtask

  // Predict the results of one accepted request into unit_results.
  // Report whether the block merely ignores it.
  task automatic transcode_unit(input in_req_t r, output bit ignored);
    out_res_t tail;
    unit_results.delete();
    if (cap_shadow == 16'd0) begin
      string_halted = 1'b1;
      high_held     = 1'b0;
    end
    ignored = string_halted && !r.last_unit;
    if (!string_halted) begin
      if (high_held) begin
        high_held = 1'b0;
        if (classify_unit(r.code_unit) == KindLow) begin
          emit_code_point(SupplStart + 21'({high_payload, r.code_unit[9:0]}));
        end else begin
          // the held high becomes a replacement, the new unit stands alone
          emit_code_point(ReplChar);
          if (!string_halted) transcode_fresh(r.code_unit, r.last_unit);
        end
      end else begin
        transcode_fresh(r.code_unit, r.last_unit);
      end
    end
    if (r.last_unit) begin
      unit_results.push_back('{8'h00, 1'b0, 1'b0, 1'b1, string_cut, bytes_out});
      high_held     = 1'b0;
      high_payload  = '0;
      bytes_out     = '0;
      string_halted = 1'b0;
      string_cut    = 1'b0;
    end
    if (unit_results.size() > 0) begin
      tail         = unit_results.pop_back();
      tail.run_end = 1'b1;
      unit_results.push_back(tail);
    end
  endtask

  // Pick an idle gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Offer one request, wait for it to be taken, record what it owes, then
  // idle for a random gap. Push stays high when the next request follows.
  task automatic send_unit(input in_req_t r, input row_check_e how, input out_res_t typed);
    bit ignored;
    int gap;
    push   <= 1'b1;
    in_req <= r;
    do @(posedge clk_i); while (full);
    transcode_unit(r, ignored);
    units_sent++;
    if (ignored) units_ignored++;
    case (how)
      RowTypedNone: ;
      RowTypedOne:  pending_utf8.push_back(typed);
      default: begin
        foreach (unit_results[i]) pending_utf8.push_back(unit_results[i]);
      end
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering, wait for every owed result, then let quiet work settle.
  task automatic drain_results(input int settle);
    int guard;
    guard = 0;
    push <= 1'b0;
    while (pending_utf8.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_utf8.size() != 0) begin
      $error("results stuck: %0d still owed", pending_utf8.size());
      errors++;
    end
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cap_shadow  = value;
    cap_writes++;
  endtask

  // Draw one code unit of a random class.
  function automatic logic [15:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 16'($urandom_range(16'h20, 16'h7E));
    if (r < 36) return ($urandom_range(0, 1) != 0) ? 16'h007F : 16'($urandom_range(1, 16'h1F));
    if (r < 54) return 16'($urandom_range(16'h80, 16'h7FF));
    if (r < 66) return 16'($urandom_range(16'h800, 16'hD7FF));
    return 16'($urandom_range(16'hE000, 16'hFFFF));
  endfunction

  // Build one source string and send it. Most strings are built from random
  // characters, pairs and lone surrogates; the rest are raw 16-bit noise with random last marks.
  task automatic send_random_string();
    in_req_t units[$];
    int      len;
    int      r;
    int      ending;
    len = $urandom_range(1, 10);
    if ($urandom_range(0, 9) < 8) begin
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          units.push_back('{random_char(), 1'b0});
        end else if (r < 90) begin
          // well-formed surrogate pair
          units.push_back('{16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0});
          units.push_back('{16'($urandom_range(16'hDC00, 16'hDFFF)), 1'b0});
        end else if (r < 95) begin
          units.push_back('{16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0});
        end else begin
          units.push_back('{16'($urandom_range(16'hDC00, 16'hDFFF)), 1'b0});
        end
      end
      ending = $urandom_range(0, 2);
      if (ending == 0) begin
        units[units.size() - 1].last_unit = 1'b1;
      end else if (ending == 1) begin
        units.push_back('{16'h0000, 1'b1});
      end else begin
        // terminator, then a unit that must be ignored closes the string
        units.push_back('{16'h0000, 1'b0});
        units.push_back('{16'($urandom_range(0, 16'hFFFF)), 1'b1});
      end
    end else begin
      for (int i = 0; i < len; i++) begin
        units.push_back('{16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 7) == 0)});
      end
    end
    foreach (units[i]) send_unit(units[i], RowPredicted, '0);
  endtask

  // Result side: check each popped result against the oldest one owed, then
  // choose pop for the next cycle. Hold off for a long stretch on request.
  initial begin
    out_res_t want;
    int       stall_left;
    int       r;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (pending_utf8.size() == 0) begin
          $error("result with nothing owed: byte %0h count %0d",
                 out_res.out_byte, out_res.byte_count);
          errors++;
        end else begin
          want = pending_utf8.pop_front();
          results_checked++;
          if (out_res.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, out_res.out_byte);
            errors++;
          end
          if (out_res.has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, out_res.has_byte);
            errors++;
          end
          if (out_res.run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, out_res.run_end);
            errors++;
          end
          if (out_res.string_done !== want.string_done) begin
            $error("string_done: expected %0b, got %0b", want.string_done, out_res.string_done);
            errors++;
          end
          if (out_res.was_cut !== want.was_cut) begin
            $error("was_cut: expected %0b, got %0b", want.was_cut, out_res.was_cut);
            errors++;
          end
          if (out_res.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, out_res.byte_count);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) stall_left = 0;
        else if (r < 95) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(10, 40);
      end
    end
  end

  // Stimulus: reset, directed rows, random phases over several capacities.
  initial begin
    dir_row_t row;
    int       cap;
    int       phase_start;
    errors          = 0;
    units_sent      = 0;
    units_ignored   = 0;
    results_checked = 0;
    cap_writes      = 0;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    cap_shadow      = CapacityReset;
    high_held       = 1'b0;
    high_payload    = '0;
    bytes_out       = '0;
    string_halted   = 1'b0;
    string_cut      = 1'b0;
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    in_req    <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows; write the capacity only once the block is idle.
    for (int i = 0; i < NumRows; i++) begin
      row = DirRows[i];
      if (row.set_cap) begin
        drain_results(SettleCycles);
        write_capacity(row.cap);
      end
      send_unit('{row.unit, row.last}, row.check, row.typed);
    end

    // Random phases: new capacity per phase, one long result hold-off, and
    // one phase with no idling on either side.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       cap = 16'hFFFF;
        1:       cap = $urandom_range(2, 24);
        2:       cap = 256;
        3:       cap = 0;
        4:       cap = $urandom_range(5, 40);
        5:       cap = 1;
        6:       cap = $urandom_range(0, 16'hFFFF);
        7:       cap = $urandom_range(2, 12);
        8:       cap = 256;
        default: cap = 16'hFFFF;
      endcase
      drain_results(SettleCycles);
      write_capacity(16'(cap));
      no_idle = (phase == 4);
      if (phase == 2) hold_req = 1'b1;
      phase_start = units_sent;
      while (units_sent - phase_start < PhaseUnits) send_random_string();
    end
    no_idle = 1'b0;

    drain_results(TailCycles);
    $display("sent %0d code units (%0d ignored after an end or cut), checked %0d results",
             units_sent, units_ignored, results_checked);
    $display("capacity written %0d times, from zero to full scale, with fill-up stall",
             cap_writes);
    if (errors == 0) begin
      $display("utf16_to_utf8_sanitizing_core verification clean");
    end else begin
      $display("utf16_to_utf8_sanitizing_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/u2u8s_pkg.sv
hw/rtl/u2u8s_front.sv
hw/rtl/u2u8s_queue.sv
hw/rtl/u2u8s_back.sv
hw/rtl/utf16_to_utf8_sanitizing_core.sv
tb/tb_utf16_to_utf8_sanitizing_core.sv
